/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the byte-map allocator.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bmffa_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the
// byte-map first-fit allocator. No dependencies.
`default_nettype none

package bmffa_pkg;

  // Pool geometry. The port widths are fixed, so the pool size is a constant.
  localparam int POOL_BYTES = 1024;
  localparam int ADDR_W     = $clog2(POOL_BYTES);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int NEED_W     = LEN_W + 1;

  localparam logic [LEN_W-1:0]  POOL_LEN  = LEN_W'(POOL_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_BYTES - 1);

  // Request kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_REALLOC = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RUN_START,
    OP_RUN_STEP,
    OP_SCAN_START,
    OP_SCAN_STEP,
    OP_FILL_START,
    OP_FILL_STEP,
    OP_RESULT
  } dp_op_t;

  // Source of the start address, count and value of a fill sweep.
  typedef enum logic [1:0] {
    FILL_SWEEP,
    FILL_MARK,
    FILL_OLD
  } fill_sel_t;

  // Which result the output register is loaded with.
  typedef enum logic [1:0] {
    RES_FAIL,
    RES_FREE,
    RES_QUERY,
    RES_GRANT
  } res_sel_t;

  typedef struct packed {
    dp_op_t    op;
    logic      run_clear;
    fill_sel_t fill_sel;
    res_sel_t  res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic  fin;
    logic  found;
    logic  size_bad;
    logic  old_zero;
    kind_t kind;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hdl/bmffa_dp.sv */
// Datapath of the byte-map allocator: the in-use map memory, the scan,
// run and fill counters, and the result register. Depends on bmffa_pkg.
`default_nettype none

module bmffa_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [bmffa_pkg::LEN_W-1:0]    in_request_size,
  input  wire logic [bmffa_pkg::ADDR_W-1:0]   in_start_address,
  input  wire bmffa_pkg::dp_cmd_t             cmd,
  output bmffa_pkg::dp_sts_t                  sts,
  output logic                                out_ok,
  output logic [bmffa_pkg::ADDR_W-1:0]        out_granted_address,
  output logic [bmffa_pkg::LEN_W-1:0]         out_run_length
);

  localparam int AW = bmffa_pkg::ADDR_W;
  localparam int LW = bmffa_pkg::LEN_W;
  localparam int NW = bmffa_pkg::NEED_W;

  // In-use map, one bit per pool byte.
  logic map_r [bmffa_pkg::POOL_BYTES];

  // Captured request.
  bmffa_pkg::kind_t kind_r, kind_nxt;
  logic [LW-1:0] size_r, size_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  // Run length of the old run (query, free, reallocate).
  logic [LW-1:0] len_r, len_nxt;

  // Sweep pointer, fill count and fill value.
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          fill_val_r, fill_val_nxt;

  // Free-run tracking of the first-fit scan.
  logic [LW-1:0] zcnt_r, zcnt_nxt;
  logic [AW-1:0] rstart_r, rstart_nxt;
  logic [AW-1:0] where_r, where_nxt;

  // Registered read of the map, tagged with its address.
  logic          rd_vld_r, rd_vld_nxt;
  logic          rd_bit_r;
  logic [AW-1:0] rd_tag_r;

  // Output register.
  logic          ok_r, ok_nxt;
  logic [AW-1:0] granted_r, granted_nxt;
  logic [LW-1:0] runlen_r, runlen_nxt;

  // Memory port controls.
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_bit;

  // Per-beat evaluation.
  logic [LW-1:0] eff_size;
  logic          size_bad;
  logic          last;
  logic          run_fin;
  logic          run_hit;
  logic [NW-1:0] zc;
  logic [AW-1:0] start;
  logic          lead;
  logic [NW-1:0] need;
  logic          scan_found;
  logic          scan_fin;
  logic          fill_fin;
  logic          fin;
  logic          stepping;
  logic          issue;

  // Reallocate never shrinks: the effective size is the larger of both.
  assign eff_size = (size_r < len_r) ? len_r : size_r;
  assign size_bad = (eff_size == '0) || (eff_size > bmffa_pkg::POOL_LEN);

  // A run ends at the first free byte or at the pool end.
  assign last    = (rd_tag_r == bmffa_pkg::LAST_ADDR);
  assign run_hit = rd_vld_r && rd_bit_r;
  assign run_fin = rd_vld_r && (!rd_bit_r || last);

  // A free run that does not begin at address 0 gives up its first byte as
  // the left neighbor; the right neighbor is needed unless the pool ends.
  assign zc         = NW'(zcnt_r) + NW'(1);
  assign start      = (zcnt_r == '0) ? rd_tag_r : rstart_r;
  assign lead       = (start != '0);
  assign need       = NW'(eff_size) + NW'(lead) + NW'(!last);
  assign scan_found = rd_vld_r && !rd_bit_r && (zc >= need);
  assign scan_fin   = rd_vld_r && (scan_found || last);

  assign fill_fin = (cnt_r == LW'(1));

  // Completion of the current step, by operation.
  always_comb begin
    case (cmd.op)
      bmffa_pkg::OP_RUN_STEP:  fin = run_fin;
      bmffa_pkg::OP_SCAN_STEP: fin = scan_fin;
      bmffa_pkg::OP_FILL_STEP: fin = fill_fin;
      default:                 fin = 1'b0;
    endcase
  end

  // Reads run one address ahead of the evaluation and stop once it ends.
  assign stepping = (cmd.op == bmffa_pkg::OP_RUN_STEP) ||
                    (cmd.op == bmffa_pkg::OP_SCAN_STEP);
  assign issue    = stepping && (ptr_r < bmffa_pkg::POOL_LEN) && !fin;
  assign rd_en    = issue;

  // Next-state logic of the datapath registers and the write port.
  always_comb begin
    kind_nxt     = kind_r;
    size_nxt     = size_r;
    addr_nxt     = addr_r;
    len_nxt      = len_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    fill_val_nxt = fill_val_r;
    zcnt_nxt     = zcnt_r;
    rstart_nxt   = rstart_r;
    where_nxt    = where_r;
    ok_nxt       = ok_r;
    granted_nxt  = granted_r;
    runlen_nxt   = runlen_r;
    rd_vld_nxt   = issue;
    wr_en        = 1'b0;
    wr_addr      = ptr_r[AW-1:0];
    wr_bit       = 1'b0;

    if (issue) begin
      ptr_nxt = ptr_r + LW'(1);
    end

    case (cmd.op)
      bmffa_pkg::OP_LOAD: begin
        kind_nxt = bmffa_pkg::kind_t'(in_kind);
        size_nxt = in_request_size;
        addr_nxt = in_start_address;
        len_nxt  = '0;
      end
      bmffa_pkg::OP_RUN_START: begin
        ptr_nxt = {1'b0, addr_r};
        len_nxt = '0;
      end
      bmffa_pkg::OP_RUN_STEP: begin
        if (run_hit) begin
          len_nxt = len_r + LW'(1);
          if (cmd.run_clear) begin
            wr_en   = 1'b1;
            wr_addr = rd_tag_r;
            wr_bit  = 1'b0;
          end
        end
      end
      bmffa_pkg::OP_SCAN_START: begin
        ptr_nxt  = '0;
        zcnt_nxt = '0;
      end
      bmffa_pkg::OP_SCAN_STEP: begin
        if (rd_vld_r) begin
          if (rd_bit_r) begin
            zcnt_nxt = '0;
          end else begin
            zcnt_nxt   = zc[LW-1:0];
            rstart_nxt = start;
          end
          if (scan_found) begin
            where_nxt = start + AW'(lead);
          end
        end
      end
      bmffa_pkg::OP_FILL_START: begin
        case (cmd.fill_sel)
          bmffa_pkg::FILL_MARK: begin
            ptr_nxt      = {1'b0, where_r};
            cnt_nxt      = eff_size;
            fill_val_nxt = 1'b1;
          end
          bmffa_pkg::FILL_OLD: begin
            ptr_nxt      = {1'b0, addr_r};
            cnt_nxt      = len_r;
            fill_val_nxt = 1'b0;
          end
          default: begin
            ptr_nxt      = '0;
            cnt_nxt      = bmffa_pkg::POOL_LEN;
            fill_val_nxt = 1'b0;
          end
        endcase
      end
      bmffa_pkg::OP_FILL_STEP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_bit  = fill_val_r;
        ptr_nxt = ptr_r + LW'(1);
        cnt_nxt = cnt_r - LW'(1);
      end
      bmffa_pkg::OP_RESULT: begin
        case (cmd.res_sel)
          bmffa_pkg::RES_FREE: begin
            ok_nxt      = 1'b1;
            granted_nxt = '0;
            runlen_nxt  = '0;
          end
          bmffa_pkg::RES_QUERY: begin
            ok_nxt      = 1'b1;
            granted_nxt = '0;
            runlen_nxt  = len_r;
          end
          bmffa_pkg::RES_GRANT: begin
            ok_nxt      = 1'b1;
            granted_nxt = where_r;
            runlen_nxt  = len_r;
          end
          default: begin
            ok_nxt      = 1'b0;
            granted_nxt = '0;
            runlen_nxt  = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_r[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit_r <= map_r[ptr_r[AW-1:0]];
      rd_tag_r <= ptr_r[AW-1:0];
    end
  end

  // Datapath registers; only the read-valid flag is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_vld_nxt;
    end
    kind_r     <= kind_nxt;
    size_r     <= size_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    ptr_r      <= ptr_nxt;
    cnt_r      <= cnt_nxt;
    fill_val_r <= fill_val_nxt;
    zcnt_r     <= zcnt_nxt;
    rstart_r   <= rstart_nxt;
    where_r    <= where_nxt;
    ok_r       <= ok_nxt;
    granted_r  <= granted_nxt;
    runlen_r   <= runlen_nxt;
  end

  // Status back to the controller.
  assign sts.fin      = fin;
  assign sts.found    = (cmd.op == bmffa_pkg::OP_SCAN_STEP) && scan_found;
  assign sts.size_bad = size_bad;
  assign sts.old_zero = (len_r == '0);
  assign sts.kind     = kind_r;

  assign out_ok              = ok_r;
  assign out_granted_address = granted_r;
  assign out_run_length      = runlen_r;

endmodule

`default_nettype wire

/* hdl/bmffa_ctrl.sv */
// Controller of the byte-map allocator: sequences the clearing pass, the
// run, scan and fill phases, and the output handshake. Depends on bmffa_pkg.
`default_nettype none

module bmffa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output bmffa_pkg::dp_cmd_t         cmd,
  input  wire bmffa_pkg::dp_sts_t    sts
);

  typedef enum logic [3:0] {
    S_SWEEP_INIT,
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_RUN,
    S_SIZE,
    S_SCAN,
    S_MARK_INIT,
    S_MARK,
    S_OLD_INIT,
    S_CLR_OLD,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  bmffa_pkg::res_sel_t   res_sel_r, res_sel_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  slot_free;

  // The output register can be reloaded when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state, commands and output-valid update.
  always_comb begin
    state_nxt     = state_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = bmffa_pkg::OP_NONE;
    cmd.run_clear = 1'b0;
    cmd.fill_sel  = bmffa_pkg::FILL_SWEEP;
    cmd.res_sel   = res_sel_r;

    case (state_r)
      S_SWEEP_INIT: begin
        cmd.op       = bmffa_pkg::OP_FILL_START;
        cmd.fill_sel = bmffa_pkg::FILL_SWEEP;
        state_nxt    = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.op = bmffa_pkg::OP_FILL_STEP;
        if (sts.fin) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = bmffa_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.kind == bmffa_pkg::KIND_ALLOC) begin
          state_nxt = S_SIZE;
        end else begin
          cmd.op    = bmffa_pkg::OP_RUN_START;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.op        = bmffa_pkg::OP_RUN_STEP;
        cmd.run_clear = (sts.kind == bmffa_pkg::KIND_FREE);
        if (sts.fin) begin
          case (sts.kind)
            bmffa_pkg::KIND_REALLOC: begin
              state_nxt = S_SIZE;
            end
            bmffa_pkg::KIND_FREE: begin
              res_sel_nxt = bmffa_pkg::RES_FREE;
              state_nxt   = S_DONE;
            end
            default: begin
              res_sel_nxt = bmffa_pkg::RES_QUERY;
              state_nxt   = S_DONE;
            end
          endcase
        end
      end
      S_SIZE: begin
        if (sts.size_bad) begin
          res_sel_nxt = bmffa_pkg::RES_FAIL;
          state_nxt   = S_DONE;
        end else begin
          cmd.op    = bmffa_pkg::OP_SCAN_START;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = bmffa_pkg::OP_SCAN_STEP;
        if (sts.fin) begin
          if (sts.found) begin
            state_nxt = S_MARK_INIT;
          end else begin
            res_sel_nxt = bmffa_pkg::RES_FAIL;
            state_nxt   = S_DONE;
          end
        end
      end
      S_MARK_INIT: begin
        cmd.op       = bmffa_pkg::OP_FILL_START;
        cmd.fill_sel = bmffa_pkg::FILL_MARK;
        state_nxt    = S_MARK;
      end
      S_MARK: begin
        cmd.op = bmffa_pkg::OP_FILL_STEP;
        if (sts.fin) begin
          if ((sts.kind == bmffa_pkg::KIND_REALLOC) && !sts.old_zero) begin
            state_nxt = S_OLD_INIT;
          end else begin
            res_sel_nxt = bmffa_pkg::RES_GRANT;
            state_nxt   = S_DONE;
          end
        end
      end
      S_OLD_INIT: begin
        cmd.op       = bmffa_pkg::OP_FILL_START;
        cmd.fill_sel = bmffa_pkg::FILL_OLD;
        state_nxt    = S_CLR_OLD;
      end
      S_CLR_OLD: begin
        cmd.op = bmffa_pkg::OP_FILL_STEP;
        if (sts.fin) begin
          res_sel_nxt = bmffa_pkg::RES_GRANT;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.op        = bmffa_pkg::OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_SWEEP_INIT;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP_INIT;
      res_sel_r   <= bmffa_pkg::RES_FAIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/byte_map_first_fit_allocator.sv */
// Byte-map first-fit allocator. The pool holds 1024 bytes, one in-use
// bit each, kept in a single-port-write, single-port-read memory.
// The input channel takes one request beat: kind, request_size and
// start_address. The output channel returns one result beat per request:
// ok, granted_address and run_length.
// After reset the block runs a clearing pass over the map (a setup
// step, then one write per byte) and holds in_ready low; the first
// request is taken after it.
// Work per request, at one map read or write per cycle:
//   query, free: a measure of L bytes, L the run length at start_address.
//   allocate: a scan up to the first fitting window (at most 1024 bytes
//     deep), then a mark of N bytes, N the request size.
//   reallocate: the run measure, then the allocate, then a clear of the
//     L bytes of the old run.
// One request is worked on at a time. A finished result sits in the
// output register; a stalled receiver does not stop the next request from
// being accepted and worked on, which then waits until the register empties.
// Depends on bmffa_pkg, bmffa_ctrl, bmffa_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module byte_map_first_fit_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [bmffa_pkg::LEN_W-1:0]    in_request_size,
  input  wire logic [bmffa_pkg::ADDR_W-1:0]   in_start_address,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_ok,
  output logic [bmffa_pkg::ADDR_W-1:0]        out_granted_address,
  output logic [bmffa_pkg::LEN_W-1:0]         out_run_length
);

  bmffa_pkg::dp_cmd_t cmd;
  bmffa_pkg::dp_sts_t sts;

  // Sequencer.
  bmffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Map memory, counters and result register.
  bmffa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_kind             (in_kind),
    .in_request_size     (in_request_size),
    .in_start_address    (in_start_address),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ok              (out_ok),
    .out_granted_address (out_granted_address),
    .out_run_length      (out_run_length)
  );

  // An accepted beat is worked on before another one is taken.
  `ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken early")

  // A failed request reports no address and no length.
  `ASSERT_IMP(a_fail_zero, out_valid && !out_ok, (out_granted_address == '0) && (out_run_length == '0), "failed result carries data")

  // A window is only found on a scan beat that also ends the scan.
  `ASSERT_IMP(a_found_ends_scan, sts.found, sts.fin && (cmd.op == bmffa_pkg::OP_SCAN_STEP), "found without end of scan")

endmodule

`default_nettype wire
